// ===== design/mlfq_pkg.sv =====
// Package for the three-level feedback queue scheduler.
// Holds field widths, command, status and register codes, and the control structs.
// No dependencies.
package mlfq_pkg;

	localparam int ID_W    = 4;
	localparam int REM_W   = 16;
	localparam int ENTRY_W = ID_W + REM_W;
	localparam int QUANT_W = 8;
	localparam int LEVEL_W = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int LEVELS  = 3;

	// Level codes
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 2'd1;

	// Reset values of the quanta
	localparam logic [QUANT_W-1:0] QUANTUM0_RESET = 8'd2;
	localparam logic [QUANT_W-1:0] QUANTUM1_RESET = 8'd4;

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_ACCEPTED  = 2'd0,
		STAT_REFUSED   = 2'd1,
		STAT_RAN       = 2'd2,
		STAT_IDLE_TICK = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/mlfq_three_level_scheduler.sv =====
// Three-level feedback queue scheduler: one result per request, registered on execute once the
// result slot is free; no new request is taken until the last one has executed, since the queue
// RAMs are read with a registered read between capture and execute.
// Reset (arst_n, asynchronous): all queues empty, slice counters zero, quanta 2 and 4;
// queue RAM contents are not cleared and no clearing pass runs.
// Depends on mlfq_pkg, mlfq_ctrl, mlfq_datapath.
module mlfq_three_level_scheduler import mlfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [ID_W-1:0]      task_id,
	input  logic [REM_W-1:0]     burst,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]   cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STAT_W-1:0]    status,
	output logic [ID_W-1:0]      run_task,
	output logic [LEVEL_W-1:0]   run_level,
	output logic                 finished,
	output logic                 demoted,
	output logic [REM_W-1:0]     remaining
);

	ctrl_cmd_t  ctrl;
	dp_status_t stat;

	mlfq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	mlfq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.cmd      (cmd),
		.task_id  (task_id),
		.burst    (burst),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.run_task (run_task),
		.run_level(run_level),
		.finished (finished),
		.demoted  (demoted),
		.remaining(remaining)
	);

endmodule

// ===== design/mlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlfq_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mlfq_ctrl.sv =====
// Controller of the scheduler: request capture and execute sequencing.
// Depends on mlfq_pkg.
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t stat,
	output ctrl_cmd_t  ctrl
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: take a request, then execute once the result slot is free
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				ctrl.capture = in_valid;
			end
			S_EXEC: begin
				ctrl.execute = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/mlfq_datapath.sv =====
// Datapath of the scheduler: queue RAMs, pointers, slice counters, quanta, result register.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_datapath import mlfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            ctrl,
	output dp_status_t           stat,
	input  logic                 cmd,
	input  logic [ID_W-1:0]      task_id,
	input  logic [REM_W-1:0]     burst,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]   cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STAT_W-1:0]    status,
	output logic [ID_W-1:0]      run_task,
	output logic [LEVEL_W-1:0]   run_level,
	output logic                 finished,
	output logic                 demoted,
	output logic [REM_W-1:0]     remaining
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = CW + 2;
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	// Per-level queue control
	logic [AW-1:0] head_q  [LEVELS];
	logic [AW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic [ENTRY_W-1:0] rdata  [LEVELS];
	logic               push   [LEVELS];
	logic               pop    [LEVELS];
	logic               wb     [LEVELS];
	logic               ram_we [LEVELS];
	logic [AW-1:0]      ram_wa [LEVELS];
	logic [ENTRY_W-1:0] ram_wd [LEVELS];

	// Captured request
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [REM_W-1:0]   burst_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic               empty_q;

	logic [QUANT_W-1:0] quantum0_q, quantum1_q;
	logic [QUANT_W-1:0] used0_q, used1_q;
	logic               out_valid_q;

	logic [LEVEL_W-1:0] lvl_sel;
	logic               all_empty;
	logic [LW-1:0]      live;
	logic               full;
	logic               arrive_ok;
	logic               run;
	logic [ENTRY_W-1:0] head_entry;
	logic [ID_W-1:0]    head_id;
	logic [REM_W-1:0]   head_rem;
	logic [REM_W-1:0]   rem_dec;
	logic               fin;
	logic [QUANT_W-1:0] used_sel;
	logic [QUANT_W-1:0] quant_sel;
	logic [QUANT_W-1:0] used_inc;
	logic               dem;
	logic [ENTRY_W-1:0] run_entry;

	assign cfg_ready = 1'b1;

	// Pick the highest non-empty level
	always_comb begin
		all_empty = 1'b0;
		if (count_q[0] != '0) begin
			lvl_sel = LEVEL_TOP;
		end else if (count_q[1] != '0) begin
			lvl_sel = LEVEL_MID;
		end else begin
			lvl_sel = LEVEL_LOW;
			all_empty = (count_q[2] == '0);
		end
	end

	// Capture the request; each RAM reads its own head at the same time
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= cmd_t'(cmd);
			id_q    <= task_id;
			burst_q <= burst;
			lvl_q   <= lvl_sel;
			empty_q <= all_empty;
		end
	end

	// Occupancy check for arrivals
	assign live = LW'(count_q[0]) + LW'(count_q[1]) + LW'(count_q[2]);
	assign full = (live >= LW'(QUEUE_DEPTH));

	assign arrive_ok = ctrl.execute && (cmd_q == CMD_ARRIVE) && !full;
	assign run       = ctrl.execute && (cmd_q == CMD_TICK) && !empty_q;

	// Head entry of the running level
	always_comb begin
		case (lvl_q)
			LEVEL_TOP: head_entry = rdata[0];
			LEVEL_MID: head_entry = rdata[1];
			default:   head_entry = rdata[2];
		endcase
	end

	assign head_id  = head_entry[ENTRY_W-1:REM_W];
	assign head_rem = head_entry[REM_W-1:0];
	assign rem_dec  = (head_rem != '0) ? head_rem - REM_W'(1) : '0;
	assign fin      = (rem_dec == '0);

	// Slice accounting and demotion decision
	assign used_sel  = (lvl_q == LEVEL_TOP) ? used0_q : used1_q;
	assign quant_sel = (lvl_q == LEVEL_TOP) ? quantum0_q : quantum1_q;
	assign used_inc  = used_sel + QUANT_W'(1);
	assign dem       = !fin && (lvl_q != LEVEL_LOW) &&
	                   ((used_inc >= quant_sel) || (used_inc == '0));
	assign run_entry = {head_id, rem_dec};

	// Push, pop and write-back per level
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			pop[l]  = run && (lvl_q == LEVEL_W'(l)) && (fin || dem);
			wb[l]   = run && (lvl_q == LEVEL_W'(l)) && !fin && !dem;
			push[l] = (l == 0) ? arrive_ok
			                   : (run && dem && (lvl_q == LEVEL_W'(l - 1)));
			ram_we[l] = push[l] || wb[l];
			ram_wa[l] = push[l] ? tail_q[l] : head_q[l];
			if (push[l] && (l == 0)) begin
				ram_wd[l] = {id_q, burst_q};
			end else begin
				ram_wd[l] = run_entry;
			end
		end
	end

	// Queue storage
	for (genvar g = 0; g < LEVELS; g++) begin : g_level
		mlfq_ram #(
			.WIDTH(ENTRY_W),
			.DEPTH(QUEUE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(ram_wa[g]),
			.wdata(ram_wd[g]),
			.re   (ctrl.capture),
			.raddr(head_q[g]),
			.rdata(rdata[g])
		);
	end

	// Advance head, tail and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				if (push[l]) begin
					tail_q[l] <= (tail_q[l] == LAST_IDX) ? '0 : tail_q[l] + AW'(1);
				end
				if (pop[l]) begin
					head_q[l] <= (head_q[l] == LAST_IDX) ? '0 : head_q[l] + AW'(1);
				end
				if (push[l] && !pop[l]) begin
					count_q[l] <= count_q[l] + CW'(1);
				end else if (pop[l] && !push[l]) begin
					count_q[l] <= count_q[l] - CW'(1);
				end
			end
		end
	end

	// Slice counters: clear on finish or demotion, else count up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used0_q <= '0;
			used1_q <= '0;
		end else if (run) begin
			if (lvl_q == LEVEL_TOP) begin
				used0_q <= (fin || dem) ? '0 : used_inc;
			end else if (lvl_q == LEVEL_MID) begin
				used1_q <= (fin || dem) ? '0 : used_inc;
			end
		end
	end

	// Quantum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum0_q <= QUANTUM0_RESET;
			quantum1_q <= QUANTUM1_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUANTUM0: quantum0_q <= cfg_data;
				REG_QUANTUM1: quantum1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Result valid: set on execute, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.execute) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			if (cmd_q == CMD_ARRIVE) begin
				status    <= full ? STAT_REFUSED : STAT_ACCEPTED;
				run_task  <= id_q;
				run_level <= LEVEL_TOP;
				finished  <= 1'b0;
				demoted   <= 1'b0;
				remaining <= burst_q;
			end else if (empty_q) begin
				status    <= STAT_IDLE_TICK;
				run_task  <= '0;
				run_level <= LEVEL_TOP;
				finished  <= 1'b0;
				demoted   <= 1'b0;
				remaining <= '0;
			end else begin
				status    <= STAT_RAN;
				run_task  <= head_id;
				run_level <= lvl_q;
				finished  <= fin;
				demoted   <= dem;
				remaining <= rem_dec;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live <= LW'(QUEUE_DEPTH))
		else $error("live task count exceeds queue depth");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> ((lvl_q == LEVEL_TOP && count_q[0] != '0) ||
		         (lvl_q == LEVEL_MID && count_q[1] != '0) ||
		         (lvl_q == LEVEL_LOW && count_q[2] != '0)))
		else $error("tick runs from an empty level");

	a_fin_excl_dem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(finished && demoted))
		else $error("result both finished and demoted");

	a_arrive_count: assert property (@(posedge clk) disable iff (!arst_n)
		arrive_ok |=> (count_q[0] == $past(count_q[0]) + CW'(1)))
		else $error("accepted arrival did not grow the top queue");
`endif

endmodule
